// ===== rtl/hid_pkg.sv =====
// Shared types and constants for the HPACK prefixed-integer decoder.
package hid_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NOT_ENOUGH = 2'd1,
        ST_INVALID    = 2'd2
    } hid_status_t;

    // Continuation groups sit at shifts 0, 7, 14, 21 and 28 (group 0..4)
    localparam int unsigned GroupBits   = 7;
    localparam int unsigned LastGroup   = 4;
    localparam logic [7:0]  LastGroupMax = 8'd15;
    localparam logic [7:0]  GroupMask   = 8'h7f;
    localparam int unsigned MoreBit     = 7;
    localparam int unsigned AccWidth    = 33;

    // One classified octet on its way from the front to the back
    typedef struct packed {
        logic       start;       // octet opens a new integer
        logic       prefix_full; // prefix is all ones, continuation follows
        logic [7:0] prefix;      // low N bits of the starting octet
        logic [7:0] octet;       // raw octet for continuation use
        logic       ends;        // last octet of the buffer
    } hid_entry_t;

    // Queue status seen by the front and the back
    typedef struct packed {
        logic not_empty;
        logic full;
    } hid_qstat_t;

endpackage

// ===== rtl/hpack_integer_decoder.sv =====
// Top level of the HPACK prefixed-integer decoder: front end, queue, back end.
//
//   Channel   Direction  Handshake           Payload
//   s_        in         s_valid / s_ready   s_data_byte, s_starts_integer,
//                                            s_prefix_bits, s_buffer_ends
//   m_        out        m_valid / m_ready   m_value, m_status
//
// One octet per cycle while the queue is not full; an accepted octet is
// first written into the queue, and the back end then steps on it and loads
// the result register once that register is free or being drained.
// The back end retires one queue entry per cycle while the result register
// is free or being drained; the queue absorbs DEPTH octets of output stall.
// Reset (aresetn low, synchronous) empties the queue and closes any integer.
module hpack_integer_decoder
    import hid_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_starts_integer,
    input  logic [3:0]  s_prefix_bits,
    input  logic        s_buffer_ends,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_value,
    output logic [1:0]  m_status
);

    hid_qstat_t q_stat;
    hid_entry_t push_entry;
    hid_entry_t head_entry;
    logic       push;
    logic       pop;

    hid_front u_front (
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_starts_integer (s_starts_integer),
        .s_prefix_bits    (s_prefix_bits),
        .s_buffer_ends    (s_buffer_ends),
        .q_stat           (q_stat),
        .push             (push),
        .push_entry       (push_entry)
    );

    hid_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .q_stat     (q_stat)
    );

    hid_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_entry (head_entry),
        .q_stat     (q_stat),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_value    (m_value),
        .m_status   (m_status)
    );

endmodule

// ===== rtl/hid_front.sv =====
// Front end: accepts octets and classifies the prefix of starting octets.
module hid_front
    import hid_pkg::*;
(
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_starts_integer,
    input  logic [3:0]  s_prefix_bits,
    input  logic        s_buffer_ends,
    input  hid_qstat_t  q_stat,
    output logic        push,
    output hid_entry_t  push_entry
);

    logic [3:0] n_clamped;
    logic [8:0] mask_wide;
    logic [7:0] mask;

    // Clamp the prefix width to 1..8
    always_comb begin
        if (s_prefix_bits == 4'd0) begin
            n_clamped = 4'd1;
        end else if (s_prefix_bits > 4'd8) begin
            n_clamped = 4'd8;
        end else begin
            n_clamped = s_prefix_bits;
        end
    end

    // All-ones prefix mask of width N
    assign mask_wide = (9'd1 << n_clamped) - 9'd1;
    assign mask      = mask_wide[7:0];

    assign s_ready = !q_stat.full;
    assign push    = s_valid && !q_stat.full;

    // Build the queue entry
    always_comb begin
        push_entry.start       = s_starts_integer;
        push_entry.prefix      = s_data_byte & mask;
        push_entry.prefix_full = ((s_data_byte & mask) == mask);
        push_entry.octet       = s_data_byte;
        push_entry.ends        = s_buffer_ends;
    end

endmodule

// ===== rtl/hid_queue.sv =====
// Short register queue between the front end and the back end.
module hid_queue
    import hid_pkg::*;
#(
    parameter int unsigned DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  hid_entry_t  push_entry,
    input  logic        pop,
    output hid_entry_t  head_entry,
    output hid_qstat_t  q_stat
);

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    hid_entry_t      mem_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;

    assign head_entry       = mem_reg[rd_ptr_reg];
    assign q_stat.not_empty = (count_reg != '0);
    assign q_stat.full      = (count_reg == FullCnt);

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + PtrW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + PtrW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CntW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FullCnt)
        else $error("queue fill count above depth");

endmodule

// ===== rtl/hid_back.sv =====
// Back end: accumulates continuation groups and drives the result register.
module hid_back
    import hid_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  hid_entry_t  head_entry,
    input  hid_qstat_t  q_stat,
    output logic        pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_value,
    output logic [1:0]  m_status
);

    logic                open_reg, open_next;
    logic [2:0]          grp_reg, grp_next;
    logic [AccWidth-1:0] acc_reg, acc_next;
    logic                m_valid_reg, m_valid_next;
    logic [31:0]         m_value_reg;
    hid_status_t         m_status_reg;

    logic                fire;
    logic                emit;
    logic [31:0]         emit_value;
    hid_status_t         emit_status;
    logic [4:0]          shift_amt;
    logic [31:0]         term;
    logic [AccWidth-1:0] acc_sum;

    // Group shift and the next partial sum
    assign shift_amt = 5'(grp_reg) * 5'(GroupBits);
    assign term      = 32'(head_entry.octet & GroupMask) << shift_amt;
    assign acc_sum   = acc_reg + AccWidth'(term);

    // Take a queue entry whenever the result register can hold a beat
    assign fire = q_stat.not_empty && (!m_valid_reg || m_ready);
    assign pop  = fire;

    // Decode step
    always_comb begin
        open_next   = open_reg;
        grp_next    = grp_reg;
        acc_next    = acc_reg;
        emit        = 1'b0;
        emit_value  = '0;
        emit_status = ST_OK;
        if (fire) begin
            if (head_entry.start) begin
                open_next = 1'b0;
                grp_next  = '0;
                acc_next  = '0;
                if (!head_entry.prefix_full) begin
                    emit       = 1'b1;
                    emit_value = 32'(head_entry.prefix);
                end else if (head_entry.ends) begin
                    emit        = 1'b1;
                    emit_status = ST_NOT_ENOUGH;
                end else begin
                    open_next = 1'b1;
                    acc_next  = AccWidth'(head_entry.prefix);
                end
            end else if (open_reg) begin
                if ((grp_reg == 3'(LastGroup)) && (head_entry.octet > LastGroupMax)) begin
                    open_next   = 1'b0;
                    grp_next    = '0;
                    acc_next    = '0;
                    emit        = 1'b1;
                    emit_status = ST_INVALID;
                end else if (!head_entry.octet[MoreBit]) begin
                    open_next  = 1'b0;
                    grp_next   = '0;
                    acc_next   = '0;
                    emit       = 1'b1;
                    emit_value = acc_sum[31:0];
                end else if (head_entry.ends) begin
                    open_next   = 1'b0;
                    grp_next    = '0;
                    acc_next    = '0;
                    emit        = 1'b1;
                    emit_status = ST_NOT_ENOUGH;
                end else begin
                    acc_next = acc_sum;
                    grp_next = grp_reg + 3'd1;
                end
            end
        end
    end

    // Result register handshake
    always_comb begin
        m_valid_next = m_valid_reg;
        if (fire && emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg    <= 1'b0;
            grp_reg     <= '0;
            acc_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            open_reg    <= open_next;
            grp_reg     <= grp_next;
            acc_reg     <= acc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload, loaded with each new beat
    always_ff @(posedge aclk) begin
        if (fire && emit) begin
            m_value_reg  <= emit_value;
            m_status_reg <= emit_status;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_value  = m_value_reg;
    assign m_status = m_status_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_status_reg != ST_OK)) |-> (m_value_reg == '0))
        else $error("error result carries a nonzero value");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !open_reg |-> ((grp_reg == '0) && (acc_reg == '0)))
        else $error("closed integer left state behind");

    assert property (@(posedge aclk) disable iff (!aresetn)
        grp_reg <= 3'(LastGroup))
        else $error("continuation group past the last shift");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && emit && (emit_status == ST_INVALID)) |-> (grp_reg == 3'(LastGroup)))
        else $error("invalid integer flagged before the last group");

endmodule
